// ===== rtl/dwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwa_pkg: shared definitions for the decimated window averager
// Field widths, register indexes, operation codes and divider status.
// ----------------------------------------------------------------------------
package dwa_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int CH_PORT_W  = 3;
	localparam int CNT_W      = 12;
	localparam int DEC_W      = 8;
	localparam int WLEN_W     = 5;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam int DEF_NUM_CHANNELS = 8;
	localparam int DEF_MAX_WINDOW   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 1'b1;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage
`default_nettype wire

// ===== rtl/dwa_tick_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwa_tick_if: input channel of the averager
// One beat is a conversion tick with a sample, or a channel clear.
// ----------------------------------------------------------------------------
interface dwa_tick_if;
	logic                         valid;
	logic                         ready;
	dwa_pkg::op_t                 op;
	logic [dwa_pkg::CH_PORT_W-1:0] channel;
	logic [dwa_pkg::SAMPLE_W-1:0]  sample;

	modport source(output valid, op, channel, sample, input ready);
	modport sink(input valid, op, channel, sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/dwa_mean_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwa_mean_if: result channel of the averager
// One beat carries the channel mean and its valid and full flags.
// ----------------------------------------------------------------------------
interface dwa_mean_if;
	logic                        valid;
	logic                        ready;
	logic [dwa_pkg::SAMPLE_W-1:0] average;
	logic                        valid_res;
	logic                        full_res;

	modport source(output valid, average, valid_res, full_res, input ready);
	modport sink(input valid, average, valid_res, full_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/dwa_serdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwa_serdiv: bit-serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwa_serdiv #(
	parameter int DIVIDEND_W = 14,
	parameter int DIVISOR_W  = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0]      quotient,
	output logic [DIVISOR_W-1:0]       remainder,
	output dwa_pkg::div_status_t       status
);
	import dwa_pkg::*;

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = ~diff[DIVISOR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
`default_nettype wire

// ===== rtl/decimated_window_averager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimated_window_averager: per-channel decimating boxcar mean
// Beats on ticks carry a sample tick or a clear for one channel; every beat
// returns exactly one beat on means, with the channel's truncated mean when valid_res is set.
// cfg_wr_en, cfg_index and cfg_data set decimation and window length; write
// them only while no beat is in flight.
// Throughput is one beat at a time. A clear or an out-of-range channel goes
// straight to the output state with an empty result. A tick runs the serial
// divider once for counter / decimation and, when entries are counted, once
// more for sum / n, after the sum walks the n stored entries through the
// single read port of the sample store. The input is ready again once the
// result has moved into the output register.
// Reset clears tick counters, full flags and the handshake state; the sample
// store holds no reset value and needs no clearing pass.
// A stalled receiver holds the result in the output register; the next beat
// is still taken and worked, and waits for that register before it lands.
// ----------------------------------------------------------------------------
module decimated_window_averager #(
	parameter int NUM_CHANNELS = dwa_pkg::DEF_NUM_CHANNELS,
	parameter int MAX_WINDOW   = dwa_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [dwa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dwa_pkg::CFG_DATA_W-1:0] cfg_data,
	dwa_tick_if.sink                            ticks,
	dwa_mean_if.source                          means
);
	import dwa_pkg::*;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int W_W      = $clog2(MAX_WINDOW + 1);
	localparam int DEPTH    = NUM_CHANNELS * MAX_WINDOW;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W    = $clog2(MAX_WINDOW * ((1 << SAMPLE_W) - 1) + 1);
	localparam int DIV_W    = (SUM_W > CNT_W) ? SUM_W : CNT_W;
	localparam int DVS_W    = (W_W > DEC_W) ? W_W : DEC_W;
	localparam int WD_W     = W_W + DEC_W;
	localparam int CMP_W    = (WD_W > CNT_W) ? WD_W : CNT_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV1 = 6'b000010,
		S_UPD  = 6'b000100,
		S_SUM  = 6'b001000,
		S_DIV2 = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                state_q;

	logic [DEC_W-1:0]      dec_q;
	logic [WLEN_W-1:0]     wlen_q;
	logic [DEC_W-1:0]      d_eff;
	logic [W_W-1:0]        w_eff;

	logic [CNT_W-1:0]      cnt_q [NUM_CHANNELS];
	logic                  full_q [NUM_CHANNELS];

	logic [SAMPLE_W-1:0]   store_mem [DEPTH];
	logic [SAMPLE_W-1:0]   rd_data_s1;
	logic                  rd_vld_s1;

	logic [CH_IDX_W-1:0]   ch_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [DIV_W-1:0]      quo_q;
	logic [DVS_W-1:0]      rem_q;
	logic [W_W-1:0]        n_q;
	logic [W_W-1:0]        idx_q;
	logic [SUM_W-1:0]      sum_q;

	logic [SAMPLE_W-1:0]   res_avg_q;
	logic                  res_valid_q;
	logic                  res_full_q;

	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   out_avg_q;
	logic                  out_vres_q;
	logic                  out_full_q;

	logic                  accept;
	logic                  in_range;
	logic [CH_IDX_W-1:0]   ch_in;
	logic                  div_start;
	logic [DIV_W-1:0]      div_dividend;
	logic [DVS_W-1:0]      div_divisor;
	logic [DIV_W-1:0]      div_quo;
	logic [DVS_W-1:0]      div_rem;
	div_status_t           div_sts;

	logic [DIV_W:0]        q_ext;
	logic [DIV_W:0]        q_inc;
	logic [CNT_W-1:0]      cnt_inc;
	logic [WD_W-1:0]       wd;
	logic                  wrap;
	logic                  full_new;
	logic [W_W-1:0]        n_part;
	logic [W_W-1:0]        n_new;
	logic                  mem_we;
	logic [ADDR_W-1:0]     ch_base;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [ADDR_W-1:0]     mem_raddr;
	logic                  issue;
	logic                  sweep_done;
	logic                  out_load;

	assign d_eff = (dec_q == '0) ? DEC_W'(1) : dec_q;

	always_comb begin
		priority if (wlen_q == '0) begin
			w_eff = W_W'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			w_eff = W_W'(MAX_WINDOW);
		end else begin
			w_eff = W_W'(wlen_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q  <= DEC_W'(1);
			wlen_q <= WLEN_W'(8);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DECIMATION: dec_q  <= cfg_data[DEC_W-1:0];
				CFG_WINDOW:     wlen_q <= cfg_data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign ticks.ready = (state_q == S_IDLE);
	assign accept      = ticks.valid && ticks.ready;
	assign in_range    = 32'(ticks.channel) < NUM_CHANNELS;
	assign ch_in       = CH_IDX_W'(ticks.channel);

	assign sweep_done  = (state_q == S_SUM) && (idx_q == n_q) && !rd_vld_s1;
	assign issue       = (state_q == S_SUM) && (idx_q < n_q);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(sum_q);
		div_divisor  = DVS_W'(n_q);
		if (accept && in_range && ticks.op == OP_TICK) begin
			div_start    = 1'b1;
			div_dividend = DIV_W'(cnt_q[ch_in]);
			div_divisor  = DVS_W'(d_eff);
		end else if (sweep_done) begin
			div_start    = 1'b1;
		end
	end

	dwa_serdiv #(
		.DIVIDEND_W(DIV_W),
		.DIVISOR_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.remainder(div_rem),
		.status   (div_sts)
	);

	assign q_ext    = {1'b0, quo_q};
	assign q_inc    = q_ext + 1'b1;
	assign cnt_inc  = cnt_q[ch_q] + 1'b1;
	assign wd       = WD_W'(w_eff) * WD_W'(d_eff);
	assign wrap     = CMP_W'(cnt_inc) >= CMP_W'(wd);
	assign full_new = full_q[ch_q] || wrap;
	assign n_part   = (q_inc > (DIV_W + 1)'(w_eff)) ? w_eff : W_W'(q_inc);

	always_comb begin
		priority if (full_new) begin
			n_new = w_eff;
		end else if (cnt_inc == '0) begin
			n_new = '0;
		end else begin
			n_new = n_part;
		end
	end

	assign ch_base   = ADDR_W'(ch_q) * ADDR_W'(MAX_WINDOW);
	assign mem_we    = (state_q == S_UPD) && (rem_q == '0) && (q_ext < (DIV_W + 1)'(w_eff));
	assign mem_waddr = ch_base + ADDR_W'(quo_q[SLOT_W-1:0]);
	assign mem_raddr = ch_base + ADDR_W'(idx_q[SLOT_W-1:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= store_mem[mem_raddr];
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || means.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i]  <= '0;
				full_q[i] <= 1'b0;
			end
		end else begin
			rd_vld_s1 <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (means.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_range && ticks.op == OP_TICK) begin
							state_q <= S_DIV1;
						end else begin
							if (in_range) begin
								cnt_q[ch_in]  <= '0;
								full_q[ch_in] <= 1'b0;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_DIV1: begin
					if (div_sts.done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					cnt_q[ch_q]  <= wrap ? '0 : cnt_inc;
					full_q[ch_q] <= full_new;
					state_q      <= (n_new == '0) ? S_OUT : S_SUM;
				end
				S_SUM: begin
					if (sweep_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q        <= ch_in;
			sample_q    <= ticks.sample;
			res_avg_q   <= '0;
			res_valid_q <= 1'b0;
			res_full_q  <= 1'b0;
		end
		if (state_q == S_DIV1 && div_sts.done) begin
			quo_q <= div_quo;
			rem_q <= div_rem;
		end
		if (state_q == S_UPD) begin
			n_q        <= n_new;
			idx_q      <= '0;
			sum_q      <= '0;
			res_full_q <= full_new;
		end
		if (issue) begin
			idx_q <= idx_q + 1'b1;
		end
		if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
		end
		if (state_q == S_DIV2 && div_sts.done) begin
			res_avg_q   <= div_quo[SAMPLE_W-1:0];
			res_valid_q <= 1'b1;
		end
		if (out_load) begin
			out_avg_q  <= res_avg_q;
			out_vres_q <= res_valid_q;
			out_full_q <= res_full_q;
		end
	end

	assign means.valid     = out_valid_q;
	assign means.average   = out_avg_q;
	assign means.valid_res = out_vres_q;
	assign means.full_res  = out_full_q;

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !ticks.ready)
		else $error("second beat taken while one is in flight");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ticks.ready |-> !div_sts.busy)
		else $error("input ready while divider busy");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(means.valid && !means.valid_res) |-> (means.average == '0 && !means.full_res))
		else $error("result with no entries carries a mean or full flag");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (idx_q <= n_q && n_q <= w_eff))
		else $error("sum sweep index out of window");

endmodule
`default_nettype wire
